/* rtl/core/ebaf_pkg.sv */
// Shared types, register codes and constants of the envelope-biased arctangent fuzz.
package ebaf_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 2'd3;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] DRIVE_RST = 16'd32768;
  localparam logic [CFG_DATA_W-1:0] LEVEL_RST = 16'd32768;
  localparam logic [CFG_DATA_W-1:0] BIAS_RST  = 16'd32768;

  // Arithmetic constants
  localparam int GAIN_FRAC  = 16;
  localparam int ANGLE_FRAC = 30;
  localparam int GAIN_W     = 23;              // 5*2^16 + 100*65535 fits
  localparam int GAIN_BASE  = 5 * 65536;
  localparam int GAIN_STEP  = 100;
  localparam int BIAS_SHIFT = 14;              // env*bias*4/(5*2^16) = (env*bias>>14)/5
  localparam int BIAS_DEN   = 5;
  localparam int DECAY_MUL  = 99;
  localparam int DECAY_SHIFT = 2;              // env*99/100 = (env*99>>2)/25
  localparam int DECAY_DEN  = 25;

  // Arctangent table, atan(2^-i) in Q2.30, truncated
  localparam int TABLE_LEN  = 32;
  localparam int ITER_IDX_W = 5;
  localparam int ANGLE_W    = 32;
  localparam logic [ANGLE_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // Controller to datapath commands
  typedef struct packed {
    logic                  load;         // capture item, raise envelope
    logic                  mul1;         // env*bias, env*99, gain
    logic                  div;          // both constant divisions
    logic                  add;          // u = x + offset, envelope decay
    logic                  mul2;         // v = u * gain, CORDIC init
    logic                  cordic_step;  // one vectoring iteration
    logic [ITER_IDX_W-1:0] iter;         // iteration index
    logic                  mul3;         // angle * level
    logic                  rnd;          // round and rescale
    logic                  finish;       // rectify, saturate, load output
  } ebaf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register empty or being taken this cycle
  } ebaf_sts_t;

endpackage

/* rtl/core/ebaf_cdiv.sv */
// Divider by a constant using a reciprocal multiply, quotient registered on load.
module ebaf_cdiv #(
  parameter int W   = 29,
  parameter int DEN = 5
) (
  input  logic         clk,
  input  logic         load,
  input  logic [W-1:0] num,
  output logic [W-1:0] quot
);

  // floor(n / DEN) = (n * M) >> K, exact for every W-bit n
  localparam int K   = W + $clog2(DEN);
  localparam int M_W = W + 1;
  localparam int P_W = W + M_W;
  localparam logic [M_W-1:0] M_C =
    M_W'(((longint'(1) << K) + longint'(DEN) - longint'(1)) / longint'(DEN));

  logic [W-1:0]   q_r;
  logic [P_W-1:0] prod;

  assign prod = P_W'(num) * P_W'(M_C);

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= W'(prod >> K);
    end
  end

  assign quot = q_r;

endmodule

/* rtl/core/ebaf_ctrl.sv */
// Sequencing state machine of the fuzz: steps the datapath through one item.
module ebaf_ctrl #(
  parameter int ITERS     = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ebaf_pkg::ebaf_sts_t sts,
  output ebaf_pkg::ebaf_cmd_t cmd
);
  import ebaf_pkg::*;

  localparam int CNT_W     = ITER_IDX_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_CORD  = 4'd5;
  localparam logic [3:0] S_MUL3  = 4'd6;
  localparam logic [3:0] S_RND   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state, step counter and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.iter  = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ITERS - 1)) begin
          state_nxt = S_MUL3;
        end
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for room in the output register
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* rtl/core/ebaf_dp.sv */
// Datapath of the fuzz: settings, envelope, gain, CORDIC arctangent, output stage.
module ebaf_dp #(
  parameter int SB    = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [ebaf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ebaf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [SB-1:0]                     in_sample,
  input  logic                              in_last,
  input  ebaf_pkg::ebaf_cmd_t               cmd,
  output ebaf_pkg::ebaf_sts_t               sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SB-1:0]                     out_sample,
  output logic                              out_last
);
  import ebaf_pkg::*;

  localparam int DW   = SB + 5;                  // divider numerator width
  localparam int BP_W = SB + CFG_DATA_W;          // env * bias
  localparam int DP_W = SB + 7;                  // env * 99
  localparam int U_W  = SB + 2;                  // sample plus offset
  localparam int V_W  = U_W + GAIN_W + 1;        // u * gain
  localparam int CD_W = SB + 28;                 // CORDIC x/y with growth
  localparam int R_W  = ANGLE_W + CFG_DATA_W + 1; // angle * level
  localparam int RS_W = R_W + 1;
  localparam int SH   = ANGLE_FRAC + GAIN_FRAC + 2 - (SB - 1);

  localparam logic signed [CD_W-1:0] CX_INIT  = CD_W'(1) << (SB - 1 + GAIN_FRAC);
  localparam logic signed [RS_W-1:0] RND_HALF = RS_W'(1) << (SH - 1);
  localparam logic signed [RS_W-1:0] MAXV     = (RS_W'(1) << (SB - 1)) - RS_W'(1);
  localparam logic signed [RS_W-1:0] MINV     = -MAXV - RS_W'(1);

  // Settings
  logic [CFG_DATA_W-1:0] drive_r, level_r, bias_r;
  logic                  oct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= DRIVE_RST;
      level_r <= LEVEL_RST;
      oct_r   <= 1'b0;
      bias_r  <= BIAS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DRIVE:  drive_r <= cfg_data;
        REG_LEVEL:  level_r <= cfg_data;
        REG_OCTAVE: oct_r   <= cfg_data[0];
        REG_BIAS:   bias_r  <= cfg_data;
      endcase
    end
  end

  // Item registers
  logic signed [SB-1:0]     x_r;
  logic                     last_r;
  logic [SB-1:0]            env_r;
  logic [BP_W-1:0]          bp_r;
  logic [DP_W-1:0]          dp_r;
  logic [GAIN_W-1:0]        gain_r;
  logic signed [U_W-1:0]    u_r;
  logic signed [CD_W-1:0]   cx_r, cy_r;
  logic signed [ANGLE_W-1:0] z_r;
  logic signed [R_W-1:0]    r_r;
  logic signed [RS_W-1:0]   rr_r;
  logic [SB-1:0]            out_sample_r;
  logic                     out_last_r;
  logic                     out_valid_r;

  // Magnitude of the incoming sample; the most negative value maps to 2^(SB-1)
  logic signed [SB-1:0] in_x;
  logic [SB-1:0]        in_mag;
  assign in_x   = signed'(in_sample);
  assign in_mag = in_x[SB-1] ? (~in_sample + 1'b1) : in_sample;

  // Constant dividers for the bias offset and the envelope decay
  logic [DW-1:0] bq, dq;

  ebaf_cdiv #(.W(DW), .DEN(BIAS_DEN)) u_div_bias (
    .clk  (clk),
    .load (cmd.div),
    .num  (DW'(bp_r >> BIAS_SHIFT)),
    .quot (bq)
  );

  ebaf_cdiv #(.W(DW), .DEN(DECAY_DEN)) u_div_decay (
    .clk  (clk),
    .load (cmd.div),
    .num  (DW'(dp_r >> DECAY_SHIFT)),
    .quot (dq)
  );

  // Products
  logic signed [GAIN_W:0]     gain_s;
  logic signed [V_W-1:0]      v_prod;
  logic signed [CFG_DATA_W:0] level_s;
  logic signed [R_W-1:0]      r_prod;
  assign gain_s  = signed'({1'b0, gain_r});
  assign v_prod  = V_W'(u_r) * V_W'(gain_s);
  assign level_s = signed'({1'b0, level_r});
  assign r_prod  = R_W'(z_r) * R_W'(level_s);

  // CORDIC vectoring step
  logic signed [CD_W-1:0]    dx, dy;
  logic signed [ANGLE_W-1:0] tab;
  assign dx  = cy_r >>> cmd.iter;
  assign dy  = cx_r >>> cmd.iter;
  assign tab = signed'(ATAN_TAB[cmd.iter]);

  // Rounding, rectification and saturation
  logic signed [RS_W-1:0] rsum, rabs;
  logic [SB-1:0]          sat;
  assign rsum = RS_W'(r_r) + RND_HALF;
  assign rabs = (oct_r && rr_r[RS_W-1]) ? -rr_r : rr_r;

  always_comb begin
    priority if (rabs > MAXV) begin
      sat = MAXV[SB-1:0];
    end else if (rabs < MINV) begin
      sat = MINV[SB-1:0];
    end else begin
      sat = rabs[SB-1:0];
    end
  end

  // Envelope is state and resets; the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (cmd.load) begin
      if (in_mag > env_r) begin
        env_r <= in_mag;
      end
    end else if (cmd.add) begin
      env_r <= dq[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_x;
      last_r <= in_last;
    end
    if (cmd.mul1) begin
      bp_r   <= BP_W'(env_r) * BP_W'(bias_r);
      dp_r   <= DP_W'(env_r) * DP_W'(DECAY_MUL);
      gain_r <= GAIN_W'(GAIN_BASE) + GAIN_W'(drive_r) * GAIN_W'(GAIN_STEP);
    end
    if (cmd.add) begin
      u_r <= U_W'(x_r) + signed'({2'b00, bq[SB-1:0]});
    end
    if (cmd.mul2) begin
      cx_r <= CX_INIT;
      cy_r <= CD_W'(v_prod);
      z_r  <= '0;
    end else if (cmd.cordic_step) begin
      if (!cy_r[CD_W-1]) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + tab;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - tab;
      end
    end
    if (cmd.mul3) begin
      r_r <= r_prod;
    end
    if (cmd.rnd) begin
      rr_r <= rsum >>> SH;
    end
    if (cmd.finish) begin
      out_sample_r <= sat;
      out_last_r   <= last_r;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_last     = out_last_r;

endmodule

/* rtl/core/envelope_biased_atan_fuzz_unit.sv */
// Envelope-biased arctangent fuzz: top level with stream ports and config channel.
// Each item runs through the states load, mul1, div, add, mul2, CORDIC, mul3, round and finish;
// out_tvalid rises after finish. The block takes no new item until the current one has finished;
// both constant divisions are reciprocal multiplies. out_tready low stalls the
// last step until the output register frees; a finished result waits there meanwhile.
// Reset (rst_n low, synchronous): settings to defaults, envelope to zero, no result pending.
module envelope_biased_atan_fuzz_unit #(
  parameter int SAMPLE_BITS     = 24,
  parameter int ATAN_ITERATIONS = 20,
  localparam int TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ebaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebaf_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [TDATA_W-1:0]              in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  input  logic                            in_tlast,   // last_in
  // output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [TDATA_W-1:0]              out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  output logic                            out_tlast   // last_out
);
  import ebaf_pkg::*;

  ebaf_cmd_t           cmd;
  ebaf_sts_t           sts;
  logic [SAMPLE_BITS-1:0] out_sample;

  assign cfg_ready = 1'b1;

  ebaf_ctrl #(
    .ITERS     (ATAN_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ebaf_dp #(
    .SB    (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_sample),
    .out_last   (out_tlast)
  );

  assign out_tdata = TDATA_W'(out_sample);

  // Block is busy right after taking an item
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  // A result appears only from a finish command
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.finish))
    else $error("result valid without a finished item");

  // Finish never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

endmodule

/* test/ebaf_fuzz_checker.sv */
// Checker for the fuzz unit: watches all three channels, predicts each shaped sample, compares.
module ebaf_fuzz_checker #(
  parameter int SAMPLE_BITS     = 24,
  parameter int ATAN_ITERATIONS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ebaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebaf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  input  logic                            in_tlast,   // last_in
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  input  logic                            out_tlast,  // last_out
  output int                              fail_count,
  output int                              shaped_due,
  output int                              samples_taken,
  output int                              results_taken,
  output int                              writes_taken
);

  localparam int FRAC        = SAMPLE_BITS - 1;
  localparam int ANGLE_SHIFT = 30 + 16 + 2 - FRAC;
  localparam int REPORT_LINES = 40;

  // atan(2^-i) in Q2.30, truncated
  localparam longint ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } shaped_item_t;

  // shadow settings and envelope
  logic [ebaf_pkg::CFG_DATA_W-1:0] drive_q, level_q, bias_q;
  logic                            octave_q;
  longint unsigned                 env_mag;
  shaped_item_t                    pending_shaped[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= REPORT_LINES)
      $display("mismatch at result %0d: %s got %0h, want %0h", results_taken, what, got, want);
  endtask

  // envelope raise, biased drive, CORDIC arctangent, level, rectify, saturate, decay
  function automatic logic [SAMPLE_BITS-1:0] shape_sample(input logic [SAMPLE_BITS-1:0] s);
    longint x, u, v, cx, cy, z, r, dx, dy, max_out, min_out;
    longint unsigned mag, off, gain;
    x = $signed(s);
    mag = (x < 0) ? longint'(-x) : longint'(x);
    if (mag > env_mag) env_mag = mag;
    off = (env_mag * longint'(bias_q) * 4) / (5 * 65536);
    u = x + longint'(off);
    gain = 5 * 65536 + 100 * longint'(drive_q);
    v = u * longint'(gain);
    cx = longint'(1) << (FRAC + 16);
    cy = v;
    z = 0;
    for (int i = 0; i < ATAN_ITERATIONS && i < 32; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + ATAN_Q30[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - ATAN_Q30[i];
      end
    end
    r = z * longint'(level_q);
    r = (r + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
    if (octave_q && r < 0) r = -r;
    max_out = (longint'(1) << FRAC) - 1;
    min_out = -max_out - 1;
    if (r > max_out) r = max_out;
    if (r < min_out) r = min_out;
    env_mag = (env_mag * 99) / 100;
    env_mag = env_mag & ((longint'(1) << SAMPLE_BITS) - 1);
    return r[SAMPLE_BITS-1:0];
  endfunction

  // results are popped before new items are pushed within one edge
  always @(posedge clk) begin
    shaped_item_t want;
    if (!rst_n) begin
      drive_q       = ebaf_pkg::DRIVE_RST;
      level_q       = ebaf_pkg::LEVEL_RST;
      bias_q        = ebaf_pkg::BIAS_RST;
      octave_q      = 1'b0;
      env_mag       = 0;
      pending_shaped.delete();
      fail_count    = 0;
      samples_taken = 0;
      results_taken = 0;
      writes_taken  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_taken++;
        if (pending_shaped.size() == 0) begin
          report_mismatch("result with no sample waiting", out_tdata[SAMPLE_BITS-1:0], '0);
        end else begin
          want = pending_shaped.pop_front();
          if (out_tdata[SAMPLE_BITS-1:0] !== want.sample)
            report_mismatch("sample_out", out_tdata[SAMPLE_BITS-1:0], want.sample);
          if (out_tlast !== want.last)
            report_mismatch("last_out", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready) begin
        samples_taken++;
        want.sample = shape_sample(in_tdata[SAMPLE_BITS-1:0]);
        want.last   = in_tlast;
        pending_shaped.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        writes_taken++;
        case (cfg_index)
          ebaf_pkg::REG_DRIVE:  drive_q  = cfg_data;
          ebaf_pkg::REG_LEVEL:  level_q  = cfg_data;
          ebaf_pkg::REG_OCTAVE: octave_q = cfg_data[0];
          ebaf_pkg::REG_BIAS:   bias_q   = cfg_data;
          default: ;
        endcase
      end
    end
    shaped_due = pending_shaped.size();
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the fuzz unit: clock, reset, stimulus, stalls, watchdog and verdict.
module tb_top;

  localparam int SAMPLE_BITS     = 24;
  localparam int ATAN_ITERATIONS = 20;
  localparam int TDATA_W         = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = SAMPLE_BITS + ATAN_ITERATIONS + 20;
  localparam int RANDOM_BLOCKS   = 10;
  localparam int BLOCK_ITEMS     = 85;
  localparam int CLOSING_ITEMS   = 100;
  localparam int DIRECTED_N      = 20;

  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // extremes and a few mid values, split over four settings
  localparam logic [SAMPLE_BITS-1:0] DIRECTED [DIRECTED_N] = '{
    24'h000000, S_MAX, S_MIN, 24'h000001, 24'hFFFFFF, 24'h400000, 24'hC00000,
    S_MIN, S_MAX, 24'h000000, 24'hFFFFFF, S_MIN, 24'hFFFFFE,
    S_MAX, S_MIN, 24'h003039,
    S_MIN, 24'hFFEC78, S_MAX, 24'h000001
  };

  localparam logic [ebaf_pkg::CFG_IDX_W-1:0] REG_LIST [4] = '{
    ebaf_pkg::REG_DRIVE, ebaf_pkg::REG_LEVEL, ebaf_pkg::REG_OCTAVE, ebaf_pkg::REG_BIAS
  };

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ebaf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ebaf_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [TDATA_W-1:0]              in_tdata;   // [SAMPLE_BITS-1:0] sample_in
  logic                            in_tlast;   // last_in
  logic                            out_tvalid;
  logic                            out_tready;
  logic [TDATA_W-1:0]              out_tdata;  // [SAMPLE_BITS-1:0] sample_out
  logic                            out_tlast;  // last_out

  int fail_count, shaped_due, samples_taken, results_taken, writes_taken;
  int quiet_cycles = 0;
  int stall_left   = 0;
  int tx_pct       = 0;
  int rx_pct       = 0;
  bit calm         = 1'b0;
  int settings_used = 1;

  envelope_biased_atan_fuzz_unit #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .ATAN_ITERATIONS (ATAN_ITERATIONS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ebaf_fuzz_checker #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .ATAN_ITERATIONS (ATAN_ITERATIONS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .shaped_due    (shaped_due),
    .samples_taken (samples_taken),
    .results_taken (results_taken),
    .writes_taken  (writes_taken)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: ready with random stall bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < rx_pct) stall_left = $urandom_range(1, 18);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one sample item, with an optional sender gap first
  task automatic drive_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
    if (!calm && $urandom_range(0, 99) < tx_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(s);
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // cfg_valid is left high; the caller lowers it after the last write
  task automatic write_setting(input logic [ebaf_pkg::CFG_IDX_W-1:0] idx,
                               input logic [ebaf_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (shaped_due != 0);
  endtask

  task automatic write_all_settings(input logic [15:0] drive, input logic [15:0] level,
                                    input logic [15:0] octave, input logic [15:0] bias);
    write_setting(ebaf_pkg::REG_DRIVE, drive);
    write_setting(ebaf_pkg::REG_LEVEL, level);
    write_setting(ebaf_pkg::REG_OCTAVE, octave);
    write_setting(ebaf_pkg::REG_BIAS, bias);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_directed(input int first, input int count);
    for (int d = first; d < first + count; d++) drive_sample(DIRECTED[d], d[0]);
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  // random settings, extremes weighted; octave gets full 16-bit data to test masking
  task automatic apply_random_settings(input bit write_all);
    logic [15:0] val;
    bit          wrote;
    wrote = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (write_all || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0:       val = '0;
          1:       val = '1;
          default: val = 16'($urandom());
        endcase
        write_setting(REG_LIST[k], val);
        wrote = 1'b1;
      end
    end
    if (wrote) begin
      cfg_valid <= 1'b0;
      settings_used++;
    end
  endtask

  // loud sets the share of full-scale samples; the rest are quiet so the envelope decays
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int loud);
    logic [SAMPLE_BITS-1:0] s;
    int                     sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      case ($urandom_range(0, 4))
        0:       s = S_MAX;
        1:       s = S_MIN;
        2:       s = '0;
        3:       s = SAMPLE_BITS'(1);
        default: s = '1;
      endcase
    end else if (sel < 5 + loud) begin
      s = SAMPLE_BITS'($urandom());
    end else begin
      s = SAMPLE_BITS'($urandom_range(0, 32'd1 << $urandom_range(0, 18)));
      if ($urandom_range(0, 1) != 0) s = -s;
    end
    return s;
  endfunction

  task automatic run_random_block(input int count);
    int frame_left;
    int loud;
    frame_left = $urandom_range(1, 32);
    loud = $urandom_range(0, 90);
    for (int n = 0; n < count; n++) begin
      drive_sample(pick_sample(loud), frame_left == 1);
      frame_left--;
      if (frame_left == 0) frame_left = $urandom_range(1, 32);
    end
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  // stimulus and verdict
  initial begin
    int pcts [3];
    pcts = '{0, 10, 40};
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset defaults, all maximal, all zero, full gain without bias
    run_directed(0, 7);
    write_all_settings('1, '1, 16'hFFFF, '1);
    run_directed(7, 6);
    write_all_settings('0, '0, 16'h0002, '0);
    run_directed(13, 3);
    write_all_settings('1, '1, 16'h0001, '0);
    run_directed(16, 4);

    // random blocks with mixed stall rates on both sides
    for (int p = 0; p < RANDOM_BLOCKS; p++) begin
      apply_random_settings(p == 0);
      tx_pct = pcts[$urandom_range(0, 2)];
      rx_pct = pcts[$urandom_range(0, 2)];
      run_random_block(BLOCK_ITEMS);
    end

    // closing block at full rate
    calm = 1'b1;
    stall_left = 0;
    apply_random_settings(1'b1);
    run_random_block(CLOSING_ITEMS);

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d samples and %0d results under %0d settings (%0d register writes)",
             samples_taken, results_taken, settings_used, writes_taken);
    $display("stalls and gaps on both sides, closing block at full rate; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
